FILE: hdl/mwps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwps_pkg
// Shared types and constants for the masked word pattern scanner.
// ----------------------------------------------------------------------------
package mwps_pkg;

    localparam int DATA_W    = 32;   // memory word
    localparam int ADDR_W    = 48;   // byte address
    localparam int COUNT_W   = 32;   // match counter
    localparam int PAT_WORDS = 4;    // words held by the pattern registers
    localparam int PAT_BYTES = 16;
    localparam int PADDR_W   = 6;
    localparam int PDATA_W   = 64;

    // register map, byte address 8 * index
    typedef enum logic [2:0] {
        REG_PATTERN_LOW   = 3'd0,
        REG_PATTERN_HIGH  = 3'd1,
        REG_WILDCARD_MASK = 3'd2,
        REG_PATTERN_WORDS = 3'd3,
        REG_BASE_ADDRESS  = 3'd4,
        REG_FIRST_ONLY    = 3'd5
    } cfg_reg_t;

    // pattern bytes and their wildcard bits, byte 0 lowest
    typedef struct packed {
        logic [PAT_BYTES-1:0]   wild;
        logic [8*PAT_BYTES-1:0] bytes;
    } pattern_cfg_t;

    // chain control, common to all cells
    typedef struct packed {
        logic shift;   // an item is taken this cycle
        logic clear;   // it closes the region: cells load zero
    } scan_ctrl_t;

endpackage
`default_nettype wire

FILE: hdl/mwps_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwps_regs
// APB register file: pattern, wildcard mask, length, base address, mode.
// ----------------------------------------------------------------------------
module mwps_regs
    import mwps_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output pattern_cfg_t            pat_cfg,
    output logic      [2:0]         pattern_words,
    output logic      [ADDR_W-1:0]  base_address,
    output logic                    first_only
);

    logic [63:0]        pattern_low_reg;
    logic [63:0]        pattern_high_reg;
    logic [15:0]        wildcard_mask_reg;
    logic [2:0]         pattern_words_reg;
    logic [ADDR_W-1:0]  base_address_reg;
    logic               first_only_reg;
    logic               wr_en;
    cfg_reg_t           reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = cfg_reg_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg   <= '0;
            pattern_high_reg  <= '0;
            wildcard_mask_reg <= '0;
            pattern_words_reg <= 3'd1;
            base_address_reg  <= '0;
            first_only_reg    <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_PATTERN_LOW:   pattern_low_reg   <= pwdata;
                REG_PATTERN_HIGH:  pattern_high_reg  <= pwdata;
                REG_WILDCARD_MASK: wildcard_mask_reg <= pwdata[15:0];
                REG_PATTERN_WORDS: pattern_words_reg <= pwdata[2:0];
                REG_BASE_ADDRESS:  base_address_reg  <= pwdata[ADDR_W-1:0];
                REG_FIRST_ONLY:    first_only_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_PATTERN_LOW:   prdata = pattern_low_reg;
            REG_PATTERN_HIGH:  prdata = pattern_high_reg;
            REG_WILDCARD_MASK: prdata = {48'd0, wildcard_mask_reg};
            REG_PATTERN_WORDS: prdata = {61'd0, pattern_words_reg};
            REG_BASE_ADDRESS:  prdata = {{(PDATA_W-ADDR_W){1'b0}}, base_address_reg};
            REG_FIRST_ONLY:    prdata = {63'd0, first_only_reg};
            default:           prdata = '0;
        endcase
    end

    assign pat_cfg.bytes  = {pattern_high_reg, pattern_low_reg};
    assign pat_cfg.wild   = wildcard_mask_reg;
    assign pattern_words  = pattern_words_reg;
    assign base_address   = base_address_reg;
    assign first_only     = first_only_reg;

endmodule
`default_nettype wire

FILE: hdl/mwps_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwps_cell
// One window slot: compares the word it sees against its pattern word,
// ANDs into the match chain, and hands the word on to the next slot.
// ----------------------------------------------------------------------------
module mwps_cell
    import mwps_pkg::*;
#(
    parameter int POS = 0,   // age of the word this cell sees, in items
    parameter int NW  = 3    // width of the word count
)
(
    input  wire logic              aclk,
    input  wire scan_ctrl_t        ctrl,
    input  wire pattern_cfg_t      pat_cfg,
    input  wire logic [NW-1:0]     n_words,
    input  wire logic [DATA_W-1:0] word_in,
    output logic      [DATA_W-1:0] word_out,
    input  wire logic              ok_in,
    output logic                   ok_out
);

    logic [DATA_W-1:0] word_reg;
    logic              active;
    logic [NW-1:0]     pw_idx;
    logic              in_pat;
    logic [1:0]        sel;
    logic [31:0]       pword;
    logic [3:0]        wnib;
    logic              match;

    // this slot takes part only if it lies inside the pattern length;
    // oldest word of the window lines up with pattern word 0
    assign active = 32'(n_words) > 32'(POS);
    assign pw_idx = n_words - NW'(POS) - NW'(1);
    assign in_pat = 32'(pw_idx) < 32'(PAT_WORDS);
    assign sel    = 2'(pw_idx);
    assign pword  = pat_cfg.bytes[32*sel +: 32];
    assign wnib   = pat_cfg.wild[4*sel +: 4];

    always_comb begin
        match = 1'b1;
        for (int b = 0; b < 4; b++) begin
            if (in_pat && !wnib[b] && (word_in[8*b +: 8] != pword[8*b +: 8])) begin
                match = 1'b0;
            end
        end
    end

    assign ok_out = ok_in && (!active || match);

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            word_reg <= ctrl.clear ? '0 : word_in;
        end
    end

    assign word_out = word_reg;

endmodule
`default_nettype wire

FILE: hdl/masked_word_pattern_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// masked_word_pattern_scan
// Wildcard byte signature scan over a stream of 32-bit memory words.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready | tdata: data_word; tlast: region_last
//  m_      | out | m_tvalid/m_tready | tdata: match_address, match_count;
//          |     |                   | tuser: found; tlast: region_end
//  apb     | in  | psel/penable      | 64-bit registers at 8 * index
//
//  One item per clock unless m_ stalls. Each word enters a row of MAX_PATTERN_WORDS
//  compare cells; cell 0 sees the arriving word, the others the held window.
//  The match chain, address add and count update settle in the accept cycle
//  and are captured in the output register at the accepting edge, so the
//  result is offered on m_ from the next cycle on.
//  s_tready stays high while the output register is empty or being drained,
//  so a stall on m_ holds exactly one finished item.
//  Reset (aresetn low, synchronous) clears offset, count, first flag and the
//  output valid; configuration returns to its reset values.
// ----------------------------------------------------------------------------
module masked_word_pattern_scan
    import mwps_pkg::*;
#(
    parameter int MAX_PATTERN_WORDS = 4
)
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // input words
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [31:0]        s_tdata,   // [31:0] data_word
    input  wire logic               s_tlast,
    // results
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [79:0]        m_tdata,   // [47:0] match_address, [79:48] match_count
    output logic      [0:0]         m_tuser,   // [0] found
    output logic                    m_tlast,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int NW = $clog2(MAX_PATTERN_WORDS + 1);

    // configuration
    pattern_cfg_t       pat_cfg;
    logic [2:0]         pattern_words;
    logic [ADDR_W-1:0]  base_address;
    logic               first_only;

    // scan state
    logic [COUNT_W-1:0] offset_reg,      offset_next;
    logic [COUNT_W-1:0] count_reg,       count_next;
    logic               first_found_reg, first_found_next;

    // output register
    logic               m_valid_reg;
    logic               m_found_reg;
    logic [ADDR_W-1:0]  m_addr_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic               m_last_reg;

    logic               accept;
    scan_ctrl_t         ctrl;
    logic [NW-1:0]      n_words;
    logic [DATA_W-1:0]  chain_word [0:MAX_PATTERN_WORDS];
    logic               chain_ok   [0:MAX_PATTERN_WORDS];
    logic               tested;
    logic               hit;
    logic [COUNT_W-1:0] span;
    logic [COUNT_W-1:0] start_word;
    logic [ADDR_W-1:0]  match_addr;
    logic [COUNT_W-1:0] count_hit;

    mwps_regs u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .pat_cfg       (pat_cfg),
        .pattern_words (pattern_words),
        .base_address  (base_address),
        .first_only    (first_only)
    );

    // one output stage: take a new item whenever the slot is free or leaving
    assign s_tready   = !m_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign ctrl.shift = accept;
    assign ctrl.clear = s_tlast;

    // clamp length to 1..MAX_PATTERN_WORDS
    always_comb begin
        if (pattern_words == 3'd0) begin
            n_words = NW'(1);
        end else if (32'(pattern_words) > 32'(MAX_PATTERN_WORDS)) begin
            n_words = NW'(MAX_PATTERN_WORDS);
        end else begin
            n_words = NW'(pattern_words);
        end
    end

    // compare row: cell k sees the word k items old
    assign chain_word[0] = s_tdata;
    assign chain_ok[0]   = 1'b1;

    for (genvar k = 0; k < MAX_PATTERN_WORDS; k++) begin : g_cell
        mwps_cell #(
            .POS (k),
            .NW  (NW)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .pat_cfg  (pat_cfg),
            .n_words  (n_words),
            .word_in  (chain_word[k]),
            .word_out (chain_word[k+1]),
            .ok_in    (chain_ok[k]),
            .ok_out   (chain_ok[k+1])
        );
    end

    // a match counts only once the whole window lies inside the region
    assign span       = 32'(n_words) - 32'd1;
    assign tested     = offset_reg >= span;
    assign hit        = tested && chain_ok[MAX_PATTERN_WORDS] && !(first_only && first_found_reg);
    assign start_word = offset_reg - span;
    assign match_addr = base_address + {{(ADDR_W-COUNT_W-2){1'b0}}, start_word, 2'b00};
    assign count_hit  = (hit && (count_reg != '1)) ? count_reg + 32'd1 : count_reg;

    always_comb begin
        offset_next      = offset_reg;
        count_next       = count_reg;
        first_found_next = first_found_reg;
        if (accept) begin
            if (s_tlast) begin
                offset_next      = '0;
                count_next       = '0;
                first_found_next = 1'b0;
            end else begin
                if (offset_reg != '1) begin
                    offset_next = offset_reg + 32'd1;
                end
                count_next       = count_hit;
                first_found_next = first_found_reg || (hit && first_only);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg      <= '0;
            count_reg       <= '0;
            first_found_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            offset_reg      <= offset_next;
            count_reg       <= count_next;
            first_found_reg <= first_found_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_found_reg <= hit;
            m_addr_reg  <= hit ? match_addr : '0;
            m_count_reg <= count_hit;
            m_last_reg  <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_count_reg, m_addr_reg};
    assign m_tuser  = m_found_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire
